[design/ldq_pkg.sv]
`default_nettype none

package ldq_pkg;

  // Queue geometry (DEPTH must be a power of two: slots wrap by truncation)
  localparam int DEPTH      = 64;
  localparam int ID_BITS    = 14;
  localparam int LABEL_BITS = 16;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int ENTRY_BITS = ID_BITS + LABEL_BITS;

  // Fixed field widths of the item interfaces
  localparam int ACT_BITS  = 3;
  localparam int POS_BITS  = 7;
  localparam int VAL_BITS  = 16;
  localparam int STAT_BITS = 2;
  localparam int OCC_BITS  = 7;

  // Action codes
  localparam logic [ACT_BITS-1:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [ACT_BITS-1:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [ACT_BITS-1:0] ACT_POP_BACK   = 3'd2;
  localparam logic [ACT_BITS-1:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [ACT_BITS-1:0] ACT_INDEX      = 3'd4;
  localparam logic [ACT_BITS-1:0] ACT_SEARCH     = 3'd5;

  // Status codes
  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [ACT_BITS-1:0] action;
    logic [ID_BITS-1:0]  item_id;
    logic [POS_BITS-1:0] position;
  } ldq_in_t;

  typedef struct packed {
    logic signed [VAL_BITS-1:0] result_value;
    logic                       found;
    logic [STAT_BITS-1:0]       status;
    logic [OCC_BITS-1:0]        occupancy;
  } ldq_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture the input item
    logic exec;        // finish an item that needs no memory read
    logic issue;       // read the entry a push or index query needs
    logic commit;      // use the read entry and finish
    logic scan_start;  // read the front entry for a search
    logic scan_step;   // compare one entry, read the next
  } ldq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_read;
    logic need_scan;
    logic scan_done;
  } ldq_stat_t;

endpackage

`default_nettype wire

[design/ldq_ram.sv]
`default_nettype none

module ldq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/ldq_ctrl.sv]
`default_nettype none

module ldq_ctrl
  import ldq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire ldq_stat_t st,
  output ldq_cmd_t       cmd,
  output logic           busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  // Sequence one item through decode, read and scan steps
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    busy_nxt  = busy_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
          busy_nxt  = 1'b1;
        end
      end
      S_DECODE: begin
        if (st.need_read) begin
          cmd.issue = 1'b1;
          state_nxt = S_READ;
        end else if (st.need_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      S_READ: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
        busy_nxt   = 1'b0;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          state_nxt = S_IDLE;
          busy_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  // Hold state and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

  a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !busy_r)
    else $error("controller idle while busy");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy_r) |=> (state_r == S_DECODE))
    else $error("accepted item not decoded");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_IDLE))
    else $error("read step did not finish");

endmodule

`default_nettype wire

[design/ldq_dp.sv]
`default_nettype none

module ldq_dp
  import ldq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ldq_in_t  in_item,
  input  wire ldq_cmd_t cmd,
  output ldq_stat_t     st,
  output logic          out_valid,
  output ldq_out_t      out_item
);

  ldq_in_t               cmd_r, cmd_nxt;
  logic [ADDR_BITS-1:0]  head_r, head_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [CNT_BITS-1:0]   idx_r, idx_nxt;
  ldq_out_t              out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  rd_en;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [ENTRY_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  wr_addr;
  logic [LABEL_BITS-1:0] wr_label;

  logic [LABEL_BITS-1:0] rd_label;
  logic [ID_BITS-1:0]    rd_id;
  logic                  full, empty, is_push, pos_bad, hit, last;

  function automatic logic [ADDR_BITS-1:0] slot_of(input logic [ADDR_BITS-1:0] head,
                                                   input logic [CNT_BITS-1:0]  off);
    return head + off[ADDR_BITS-1:0];
  endfunction

  // Entry store: id in the upper bits, label in the lower bits
  ldq_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({cmd_r.item_id, wr_label}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_label = rd_data[LABEL_BITS-1:0];
  assign rd_id    = rd_data[ENTRY_BITS-1:LABEL_BITS];

  // Classify the held item
  assign full    = (count_r == CNT_BITS'(DEPTH));
  assign empty   = (count_r == '0);
  assign is_push = (cmd_r.action == ACT_PUSH_BACK) || (cmd_r.action == ACT_PUSH_FRONT);
  assign pos_bad = (cmd_r.position == '0) || (cmd_r.position > count_r);
  assign hit     = (rd_id == cmd_r.item_id);
  assign last    = (idx_r == count_r);

  assign st.need_read = (is_push && !full && !empty) ||
                        ((cmd_r.action == ACT_INDEX) && !pos_bad);
  assign st.need_scan = (cmd_r.action == ACT_SEARCH) && !empty;
  assign st.scan_done = hit || last;

  // Update queue pointers, drive the store and form the result
  always_comb begin
    cmd_nxt       = cmd_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_label      = '0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    if (cmd.load) begin
      cmd_nxt = in_item;
    end

    if (cmd.exec || cmd.commit || cmd.scan_step) begin
      out_nxt.result_value = '0;
      out_nxt.found        = 1'b0;
      out_nxt.status       = ST_OK;
    end

    // No read: pops, full push, push to empty, bad index, empty search
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
      case (cmd_r.action)
        ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
          if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = head_r;
            count_nxt = count_r + CNT_BITS'(1);
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            out_nxt.status = ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_BITS'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            out_nxt.status = ST_EMPTY;
          end else begin
            head_nxt  = head_r + ADDR_BITS'(1);
            count_nxt = count_r - CNT_BITS'(1);
          end
        end
        ACT_INDEX: begin
          out_nxt.status = ST_RANGE;
        end
        default: begin
        end
      endcase
    end

    // Read the neighbor label or the indexed entry
    if (cmd.issue) begin
      rd_en = 1'b1;
      case (cmd_r.action)
        ACT_PUSH_BACK:  rd_addr = slot_of(head_r, count_r - CNT_BITS'(1));
        ACT_PUSH_FRONT: rd_addr = head_r;
        default:        rd_addr = slot_of(head_r, CNT_BITS'(cmd_r.position - POS_BITS'(1)));
      endcase
    end

    // Use the read entry
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      case (cmd_r.action)
        ACT_PUSH_BACK: begin
          wr_en     = 1'b1;
          wr_addr   = slot_of(head_r, count_r);
          wr_label  = rd_label + LABEL_BITS'(1);
          count_nxt = count_r + CNT_BITS'(1);
        end
        ACT_PUSH_FRONT: begin
          wr_en     = 1'b1;
          wr_addr   = head_r - ADDR_BITS'(1);
          wr_label  = rd_label - LABEL_BITS'(1);
          head_nxt  = head_r - ADDR_BITS'(1);
          count_nxt = count_r + CNT_BITS'(1);
        end
        default: begin
          out_nxt.result_value = VAL_BITS'(rd_id);
          out_nxt.found        = 1'b1;
        end
      endcase
    end

    // Walk the entries from the front, one read per cycle
    if (cmd.scan_start) begin
      rd_en   = 1'b1;
      rd_addr = head_r;
      idx_nxt = CNT_BITS'(1);
    end

    if (cmd.scan_step) begin
      if (hit) begin
        out_valid_nxt        = 1'b1;
        out_nxt.result_value = rd_label;
        out_nxt.found        = 1'b1;
      end else if (last) begin
        out_valid_nxt = 1'b1;
      end else begin
        rd_en   = 1'b1;
        rd_addr = slot_of(head_r, idx_r);
        idx_nxt = idx_r + CNT_BITS'(1);
      end
    end

    out_nxt.occupancy = OCC_BITS'(count_nxt);
  end

  // Hold queue pointers and the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold item and result payload
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(DEPTH))
    else $error("entry count above depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held two cycles");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (idx_r <= count_r))
    else $error("scan index past occupancy");

endmodule

`default_nettype wire

[design/labelled_deque_with_search.sv]
// Channel   Ports                         Handshake
// input     start, busy, in_item          taken when start is high and busy is low
// result    out_valid, out_item           shown for one cycle, always taken
//
// Pop, full push, push into an empty queue and a bad position finish from the decode
// step; a push onto a non-empty queue and an index query take a read step as well,
// since the neighbor label or the entry comes through the registered read port.
// A search reads one entry per cycle from the front, stopping at the first hit
// or after the last entry on a miss.
// Synchronous active-low reset empties the queue; busy drops in the result cycle.
`default_nettype none

module labelled_deque_with_search
  import ldq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire ldq_in_t in_item,
  output logic         out_valid,
  output ldq_out_t     out_item
);

  ldq_cmd_t  cmd;
  ldq_stat_t st;

  ldq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  ldq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[bench/labelled_deque_with_search_tb.sv]
module labelled_deque_with_search_tb;
  import ldq_pkg::*;

  // Action codes the block leaves unused
  localparam logic [ACT_BITS-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_BITS-1:0] ACT_SPARE_7 = 3'd7;

  localparam int CLK_PERIOD   = 12;
  localparam int RAND_PER_PH  = 263;
  localparam int MAX_GAP      = 24;
  localparam int SETTLE_CYCLES = DEPTH + 16;
  localparam int MAX_ITEMS    = 2048;
  localparam int MAX_ROWS     = 32;

  typedef struct {
    ldq_in_t  cmd;
    bit       typed;
    ldq_out_t want;
  } step_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  ldq_in_t  in_item;
  logic     out_valid;
  ldq_out_t out_item;

  // Shadow copy of the deque
  logic [ID_BITS-1:0]    shadow_ids    [DEPTH];
  logic [LABEL_BITS-1:0] shadow_labels [DEPTH];
  logic [ADDR_BITS-1:0]  shadow_head  = '0;
  logic [CNT_BITS-1:0]   shadow_count = '0;

  // Expected results in item order: written at n_items, read at n_results
  ldq_out_t  expected_results [MAX_ITEMS];
  ldq_out_t  oldest_want;
  step_row_t directed_rows [MAX_ROWS];
  int        n_rows = 0;

  int n_err = 0;
  int n_items = 0;
  int n_results = 0;
  int n_full_drops = 0;
  int n_empty_pops = 0;
  int n_bad_pos = 0;
  int n_hits = 0;
  int n_misses = 0;
  int n_fill_rounds = 0;
  bit filling = 1'b1;

  labelled_deque_with_search u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(CLK_PERIOD * 600000);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [ADDR_BITS-1:0] slot_at(int offset);
    return shadow_head + ADDR_BITS'(offset);
  endfunction

  // Apply one item to the shadow deque and return the result it produces
  function automatic ldq_out_t deque_apply(ldq_in_t c);
    ldq_out_t              r;
    logic [LABEL_BITS-1:0] lab;
    logic [ADDR_BITS-1:0]  s;
    r = '0;
    case (c.action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (shadow_count == DEPTH) begin
          r.status = ST_FULL;
          n_full_drops++;
        end else begin
          lab = '0;
          if (c.action == ACT_PUSH_BACK) begin
            if (shadow_count != 0) lab = shadow_labels[slot_at(shadow_count - 1)] + 1'b1;
            s = slot_at(shadow_count);
          end else begin
            if (shadow_count != 0) begin
              lab = shadow_labels[shadow_head] - 1'b1;
              shadow_head = shadow_head - 1'b1;
            end
            s = shadow_head;
          end
          shadow_ids[s]    = c.item_id;
          shadow_labels[s] = lab;
          shadow_count++;
        end
      end
      ACT_POP_BACK, ACT_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
          n_empty_pops++;
        end else begin
          if (c.action == ACT_POP_FRONT) shadow_head = shadow_head + 1'b1;
          shadow_count--;
        end
      end
      ACT_INDEX: begin
        if (c.position == 0 || c.position > shadow_count) begin
          r.status = ST_RANGE;
          n_bad_pos++;
        end else begin
          r.result_value = VAL_BITS'(shadow_ids[slot_at(c.position - 1)]);
          r.found = 1'b1;
        end
      end
      ACT_SEARCH: begin
        // Scan from the front, the first hit wins
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_ids[slot_at(i)] == c.item_id) begin
            r.result_value = shadow_labels[slot_at(i)];
            r.found = 1'b1;
            break;
          end
        end
        if (r.found) n_hits++;
        else n_misses++;
      end
      default: ;
    endcase
    r.occupancy = shadow_count;
    return r;
  endfunction

  function automatic ldq_in_t mk_cmd(logic [ACT_BITS-1:0] act, logic [ID_BITS-1:0] id,
                                     logic [POS_BITS-1:0] pos);
    ldq_in_t c;
    c.action   = act;
    c.item_id  = id;
    c.position = pos;
    return c;
  endfunction

  function automatic ldq_out_t mk_res(logic [VAL_BITS-1:0] v, logic f,
                                      logic [STAT_BITS-1:0] s, logic [OCC_BITS-1:0] o);
    ldq_out_t r;
    r.result_value = v;
    r.found        = f;
    r.status       = s;
    r.occupancy    = o;
    return r;
  endfunction

  function automatic void add_row(ldq_in_t c, bit typed, ldq_out_t w);
    step_row_t row;
    row.cmd   = c;
    row.typed = typed;
    row.want  = w;
    directed_rows[n_rows] = row;
    n_rows++;
  endfunction

  // Build a random item, biased toward filling or draining the deque
  function automatic ldq_in_t random_cmd(bit grow);
    ldq_in_t c;
    int      a;
    int      k;
    a = $urandom_range(99);
    if (grow) begin
      if (a < 25)      c.action = ACT_PUSH_BACK;
      else if (a < 45) c.action = ACT_PUSH_FRONT;
      else if (a < 53) c.action = ACT_POP_BACK;
      else if (a < 60) c.action = ACT_POP_FRONT;
      else if (a < 77) c.action = ACT_INDEX;
      else if (a < 95) c.action = ACT_SEARCH;
      else             c.action = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
    end else begin
      if (a < 8)       c.action = ACT_PUSH_BACK;
      else if (a < 15) c.action = ACT_PUSH_FRONT;
      else if (a < 40) c.action = ACT_POP_BACK;
      else if (a < 65) c.action = ACT_POP_FRONT;
      else if (a < 80) c.action = ACT_INDEX;
      else if (a < 95) c.action = ACT_SEARCH;
      else             c.action = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
    end
    // Reuse stored ids often so searches hit and duplicates pile up
    a = $urandom_range(99);
    if (a < 35 && shadow_count != 0)
      c.item_id = shadow_ids[slot_at($urandom_range(shadow_count - 1))];
    else if (a < 55) c.item_id = ID_BITS'($urandom_range(7));
    else if (a < 60) c.item_id = $urandom_range(1) ? '1 : '0;
    else             c.item_id = ID_BITS'($urandom);
    // Mostly valid positions, then the edges, then anything
    a = $urandom_range(99);
    if (a < 60 && shadow_count != 0) begin
      c.position = POS_BITS'($urandom_range(shadow_count, 1));
    end else if (a < 75) begin
      k = $urandom_range(4);
      case (k)
        0:       c.position = '0;
        1:       c.position = POS_BITS'(shadow_count);
        2:       c.position = POS_BITS'(shadow_count + 1);
        3:       c.position = POS_BITS'(DEPTH);
        default: c.position = '1;
      endcase
    end else begin
      c.position = POS_BITS'($urandom);
    end
    return c;
  endfunction

  // Offer one item, hold it until taken, then idle at random
  task automatic issue(input ldq_in_t c, input bit typed, input ldq_out_t want,
                       input int idle_pct);
    ldq_out_t predicted;
    int       gap;
    start   <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = deque_apply(c);
    expected_results[n_items] = typed ? want : predicted;
    n_items++;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Check each result against the oldest outstanding one
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (n_results == n_items) begin
        $error("unexpected result: value %0d found %0b status %0d occupancy %0d",
               out_item.result_value, out_item.found, out_item.status, out_item.occupancy);
        n_err++;
      end else begin
        oldest_want = expected_results[n_results];
        n_results++;
        if (out_item.result_value !== oldest_want.result_value) begin
          $error("result_value: expected %0d, got %0d",
                 oldest_want.result_value, out_item.result_value);
          n_err++;
        end
        if (out_item.found !== oldest_want.found) begin
          $error("found: expected %0b, got %0b", oldest_want.found, out_item.found);
          n_err++;
        end
        if (out_item.status !== oldest_want.status) begin
          $error("status: expected %0d, got %0d", oldest_want.status, out_item.status);
          n_err++;
        end
        if (out_item.occupancy !== oldest_want.occupancy) begin
          $error("occupancy: expected %0d, got %0d",
                 oldest_want.occupancy, out_item.occupancy);
          n_err++;
        end
      end
    end
  end

  initial begin
    int idle_pcts [4];
    idle_pcts = '{0, 68, 0, 27};
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;

    // Edge cases on an empty deque, extremes, label wrap and duplicate ids
    add_row(mk_cmd(ACT_POP_BACK, '0, '0), 1'b1, mk_res('0, 1'b0, ST_EMPTY, 7'd0));
    add_row(mk_cmd(ACT_POP_FRONT, '1, '1), 1'b1, mk_res('0, 1'b0, ST_EMPTY, 7'd0));
    add_row(mk_cmd(ACT_INDEX, '0, 7'd1), 1'b1, mk_res('0, 1'b0, ST_RANGE, 7'd0));
    add_row(mk_cmd(ACT_SEARCH, 14'd5, '0), 1'b1, mk_res('0, 1'b0, ST_OK, 7'd0));
    add_row(mk_cmd(ACT_PUSH_BACK, '1, '0), 1'b1, mk_res('0, 1'b0, ST_OK, 7'd1));
    add_row(mk_cmd(ACT_PUSH_FRONT, '0, '1), 1'b1, mk_res('0, 1'b0, ST_OK, 7'd2));
    add_row(mk_cmd(ACT_INDEX, '1, '0), 1'b1, mk_res('0, 1'b0, ST_RANGE, 7'd2));
    add_row(mk_cmd(ACT_INDEX, '0, '1), 1'b1, mk_res('0, 1'b0, ST_RANGE, 7'd2));
    add_row(mk_cmd(ACT_INDEX, '0, 7'd1), 1'b1, mk_res('0, 1'b1, ST_OK, 7'd2));
    add_row(mk_cmd(ACT_INDEX, '0, 7'd2), 1'b1, mk_res(16'd16383, 1'b1, ST_OK, 7'd2));
    add_row(mk_cmd(ACT_SEARCH, '0, '0), 1'b1, mk_res(16'hFFFF, 1'b1, ST_OK, 7'd2));
    add_row(mk_cmd(ACT_SEARCH, '1, '0), 1'b1, mk_res('0, 1'b1, ST_OK, 7'd2));
    add_row(mk_cmd(ACT_SEARCH, 14'd100, '0), 1'b1, mk_res('0, 1'b0, ST_OK, 7'd2));
    add_row(mk_cmd(ACT_SPARE_6, '1, '1), 1'b1, mk_res('0, 1'b0, ST_OK, 7'd2));
    add_row(mk_cmd(ACT_SPARE_7, '1, 7'd1), 1'b1, mk_res('0, 1'b0, ST_OK, 7'd2));
    add_row(mk_cmd(ACT_POP_BACK, '0, '0), 1'b1, mk_res('0, 1'b0, ST_OK, 7'd1));
    add_row(mk_cmd(ACT_PUSH_BACK, 14'h2AAA, '0), 1'b1, mk_res('0, 1'b0, ST_OK, 7'd2));
    add_row(mk_cmd(ACT_SEARCH, 14'h2AAA, '0), 1'b1, mk_res('0, 1'b1, ST_OK, 7'd2));
    add_row(mk_cmd(ACT_PUSH_FRONT, 14'h2AAA, 7'h55), 1'b0, '0);
    add_row(mk_cmd(ACT_SEARCH, 14'h2AAA, 7'h2A), 1'b0, '0);
    add_row(mk_cmd(ACT_INDEX, 14'h1555, 7'd64), 1'b1, mk_res('0, 1'b0, ST_RANGE, 7'd3));
    add_row(mk_cmd(ACT_POP_FRONT, 14'h1555, '0), 1'b0, '0);
    add_row(mk_cmd(ACT_INDEX, '0, 7'd2), 1'b0, '0);
    add_row(mk_cmd(ACT_POP_BACK, '0, '0), 1'b0, '0);
    add_row(mk_cmd(ACT_POP_FRONT, '0, '0), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < n_rows; i++)
      issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want, 0);

    // Random traffic: fill until full, linger, drain until empty, repeat
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < RAND_PER_PH; k++) begin
        if (filling && shadow_count == DEPTH && $urandom_range(3) == 0) begin
          filling = 1'b0;
        end else if (!filling && shadow_count == 0 && $urandom_range(3) == 0) begin
          filling = 1'b1;
          n_fill_rounds++;
        end
        issue(random_cmd(filling), 1'b0, '0, idle_pcts[ph]);
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then let stray ones show up
    while (n_results != n_items) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d results, %0d full-to-empty rounds.",
             n_items, n_results, n_fill_rounds);
    $display("Full drops %0d, empty pops %0d, bad positions %0d, search hits %0d, misses %0d.",
             n_full_drops, n_empty_pops, n_bad_pos, n_hits, n_misses);
    if (n_err == 0 && n_results == n_items) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
